// File: rtl/pfr_pkg.sv
//------------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants of the page frame replacement unit.
//------------------------------------------------------------------------------
package pfr_pkg;

  localparam int unsigned DefFrames   = 16;
  localparam int unsigned DefAddrBits = 32;
  localparam int unsigned PageW       = 32;
  localparam int unsigned IdxOutW     = 4;
  localparam int unsigned StampW      = 32;
  localparam int unsigned OffW        = 5;
  localparam int unsigned CfgW        = 5;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] RegMode   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegOffset = 1'b1;

  localparam logic [StampW-1:0] TimeMax = '1;

  localparam logic ModeLru   = 1'b0;
  localparam logic ModeClock = 1'b1;

endpackage

// File: rtl/pfr_front.sv
//------------------------------------------------------------------------------
// pfr_front
// Accepts addresses, masks them to the address width and forms page numbers
// into a two-entry request queue toward the frame engine.
//------------------------------------------------------------------------------
module pfr_front import pfr_pkg::*; #(
  parameter int unsigned ADDR_BITS = DefAddrBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [31:0]      virtual_address_i,
  input  logic [OffW-1:0]  offset_i,
  output logic             req_valid_o,
  output logic [PageW-1:0] req_page_o,
  input  logic             req_take_i
);

  logic [PageW-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic [31:0]      addr;
  logic [PageW-1:0] page;
  logic             do_push;

  assign addr    = virtual_address_i & (32'hFFFF_FFFF >> (32 - ADDR_BITS));
  assign page    = addr >> offset_i;
  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_page_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (req_take_i && req_valid_o) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(req_take_i && req_valid_o);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("request queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !req_valid_o)
    else $error("request offered from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !req_take_i) |=> full)
    else $error("queue drained without a take");

endmodule

// File: rtl/pfr_back.sv
//------------------------------------------------------------------------------
// pfr_back
// Frame engine: scans the frame table one entry per cycle for lookup, LRU
// minimum search and the clock sweep, then updates the frame and emits a
// result into a one-entry output register.
//------------------------------------------------------------------------------
module pfr_back import pfr_pkg::*; #(
  parameter int unsigned FRAMES = DefFrames
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mode_i,
  input  logic               req_valid_i,
  input  logic [PageW-1:0]   req_page_i,
  output logic               req_take_o,
  output logic               empty,
  input  logic               pop,
  output logic               hit_o,
  output logic [IdxOutW-1:0] frame_index_o,
  output logic               evicted_valid_o,
  output logic [PageW-1:0]   evicted_page_o
);

  localparam int unsigned IdxW = $clog2(FRAMES);
  localparam int unsigned CntW = $clog2(FRAMES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_LRU   = 5'b00100,
    S_CLOCK = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e            state_q;
  logic [FRAMES-1:0] valid_q, ref_q;
  logic [PageW-1:0]  page_q  [FRAMES];
  logic [StampW-1:0] stamp_q [FRAMES];
  logic [IdxW-1:0]   hand_q, idx_q, best_q;
  logic [CntW-1:0]   cnt_q;
  logic [StampW-1:0] time_q, best_stamp_q;
  logic              best_empty_q;
  logic [PageW-1:0]  cur_page_q;
  logic              out_full_q;
  logic              res_hit_q, res_ev_q;
  logic [IdxW-1:0]   res_idx_q;
  logic [PageW-1:0]  res_page_q;
  logic              out_hit_q, out_ev_q;
  logic [IdxW-1:0]   out_idx_q;
  logic [PageW-1:0]  out_page_q;
  logic [IdxW-1:0]   idx_nx, hand_nx;
  logic              last;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] v);
    logic [IdxW-1:0] r;
    r = (32'(v) == FRAMES - 1) ? '0 : v + 1'b1;
    return r;
  endfunction

  assign idx_nx  = wrap_inc(idx_q);
  assign hand_nx = wrap_inc(hand_q);
  assign last    = (32'(idx_q) == FRAMES - 1);
  assign req_take_o = (state_q == S_IDLE) && req_valid_i;

  assign empty           = !out_full_q;
  assign hit_o           = out_hit_q;
  assign frame_index_o   = IdxOutW'(32'(out_idx_q));
  assign evicted_valid_o = out_ev_q;
  assign evicted_page_o  = out_page_q;

  // Payload tables, written only when a request resolves.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_take_o) begin
      cur_page_q <= req_page_i;
    end
    if (state_q == S_LOOK && valid_q[idx_q] && page_q[idx_q] == cur_page_q) begin
      if (mode_i == ModeLru) begin
        stamp_q[idx_q] <= time_q;
      end
      res_hit_q  <= 1'b1;
      res_idx_q  <= idx_q;
      res_ev_q   <= 1'b0;
      res_page_q <= '0;
    end
    if (state_q == S_LRU) begin
      if (!valid_q[idx_q] && !best_empty_q) begin
        best_q       <= idx_q;
        best_empty_q <= 1'b1;
      end else if (valid_q[idx_q] && !best_empty_q &&
                   (idx_q == '0 || stamp_q[idx_q] < best_stamp_q)) begin
        best_q       <= idx_q;
        best_stamp_q <= stamp_q[idx_q];
      end
      if (last) begin
        // Final candidate must be folded in here as well.
        if (!valid_q[idx_q] && !best_empty_q) begin
          res_idx_q <= idx_q;
          res_ev_q  <= 1'b0;
          res_page_q <= '0;
          page_q[idx_q]  <= cur_page_q;
          stamp_q[idx_q] <= time_q;
        end else if (best_empty_q || (idx_q != '0 && !(stamp_q[idx_q] < best_stamp_q))) begin
          res_idx_q  <= best_q;
          res_ev_q   <= valid_q[best_q];
          res_page_q <= valid_q[best_q] ? page_q[best_q] : '0;
          page_q[best_q]  <= cur_page_q;
          stamp_q[best_q] <= time_q;
        end else begin
          res_idx_q  <= idx_q;
          res_ev_q   <= 1'b1;
          res_page_q <= page_q[idx_q];
          page_q[idx_q]  <= cur_page_q;
          stamp_q[idx_q] <= time_q;
        end
        res_hit_q <= 1'b0;
      end
    end
    if (state_q == S_LOOK && last && !(valid_q[idx_q] && page_q[idx_q] == cur_page_q)) begin
      best_empty_q <= 1'b0;
      best_stamp_q <= '0;
    end
    if (state_q == S_CLOCK && (!ref_q[hand_q] || cnt_q == CntW'(FRAMES))) begin
      res_hit_q  <= 1'b0;
      res_idx_q  <= hand_q;
      res_ev_q   <= valid_q[hand_q];
      res_page_q <= valid_q[hand_q] ? page_q[hand_q] : '0;
      page_q[hand_q]  <= cur_page_q;
      stamp_q[hand_q] <= '0;
    end
    // The finished result moves to the output register once that is free.
    if (state_q == S_DONE && (!out_full_q || pop)) begin
      out_hit_q  <= res_hit_q;
      out_idx_q  <= res_idx_q;
      out_ev_q   <= res_ev_q;
      out_page_q <= res_page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      ref_q      <= '0;
      hand_q     <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      time_q     <= '0;
      out_full_q <= 1'b0;
    end else begin
      if (pop && out_full_q) begin
        out_full_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            idx_q   <= '0;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (valid_q[idx_q] && page_q[idx_q] == cur_page_q) begin
            if (mode_i == ModeClock) begin
              ref_q[idx_q] <= 1'b1;
            end else if (time_q != TimeMax) begin
              time_q <= time_q + 1'b1;
            end
            state_q <= S_DONE;
          end else if (last) begin
            idx_q   <= '0;
            cnt_q   <= '0;
            state_q <= (mode_i == ModeClock) ? S_CLOCK : S_LRU;
          end else begin
            idx_q <= idx_nx;
          end
        end
        S_LRU: begin
          if (last) begin
            if (!valid_q[idx_q] && !best_empty_q) begin
              valid_q[idx_q] <= 1'b1;
              ref_q[idx_q]   <= 1'b0;
            end else if (best_empty_q ||
                         (idx_q != '0 && !(stamp_q[idx_q] < best_stamp_q))) begin
              valid_q[best_q] <= 1'b1;
              ref_q[best_q]   <= 1'b0;
            end else begin
              valid_q[idx_q] <= 1'b1;
              ref_q[idx_q]   <= 1'b0;
            end
            if (time_q != TimeMax) begin
              time_q <= time_q + 1'b1;
            end
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_nx;
          end
        end
        S_CLOCK: begin
          if (!ref_q[hand_q] || cnt_q == CntW'(FRAMES)) begin
            valid_q[hand_q] <= 1'b1;
            ref_q[hand_q]   <= 1'b0;
            hand_q          <= hand_nx;
            state_q         <= S_DONE;
          end else begin
            ref_q[hand_q] <= 1'b0;
            hand_q        <= hand_nx;
            cnt_q         <= cnt_q + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_full_q || pop) begin
            out_full_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_full_q) |=> !empty)
    else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLOCK) |-> (cnt_q <= CntW'(FRAMES)))
    else $error("clock sweep ran past one turn");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q == TimeMax) |=> (time_q == TimeMax))
    else $error("time counter wrapped");

endmodule

// File: rtl/page_frame_replacement.sv
//------------------------------------------------------------------------------
// page_frame_replacement
// Fully associative page frame table with LRU or clock replacement.
//------------------------------------------------------------------------------
// Usage: push a virtual address while full is low; one result (hit, frame,
// evicted page) appears per request, in order, while empty is low, and is
// taken with pop. A two-entry request queue lets addresses be pushed while
// the frame engine works.
// Operation: the engine scans the frame table one frame per cycle. A hit
// ends the lookup scan at the matching frame; a miss scans the whole table
// for lookup, then runs the LRU search over all frames or a clock sweep of
// up to FRAMES+1 frames, and then posts the result. The engine takes the
// next request only after the last result has moved to the output register.
// Configuration: register 0 selects LRU (0) or clock (1), register 1 holds
// the page offset width; write only while idle.
// Reset empties all frames, zeroes the clock hand and time counter, and
// sets the page offset width to 12. When pop stays low, the engine holds a
// finished result and the queue fills, then full rises.
//------------------------------------------------------------------------------
module page_frame_replacement import pfr_pkg::*; #(
  parameter int unsigned FRAMES    = DefFrames,
  parameter int unsigned ADDR_BITS = DefAddrBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        virtual_address_i,
  output logic               empty,
  input  logic               pop,
  output logic               hit_o,
  output logic [IdxOutW-1:0] frame_index_o,
  output logic               evicted_valid_o,
  output logic [PageW-1:0]   evicted_page_o
);

  logic             mode_q;
  logic [OffW-1:0]  off_q;
  logic             req_valid, req_take;
  logic [PageW-1:0] req_page;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLru;
      off_q  <= OffW'(12);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:   mode_q <= cfg_data_i[0];
        RegOffset: off_q  <= cfg_data_i[OffW-1:0];
        default: ;
      endcase
    end
  end

  pfr_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk_i, .rst_ni, .push, .full, .virtual_address_i,
    .offset_i(off_q), .req_valid_o(req_valid), .req_page_o(req_page),
    .req_take_i(req_take)
  );

  pfr_back #(.FRAMES(FRAMES)) u_back (
    .clk_i, .rst_ni, .mode_i(mode_q), .req_valid_i(req_valid),
    .req_page_i(req_page), .req_take_o(req_take), .empty, .pop,
    .hit_o, .frame_index_o, .evicted_valid_o, .evicted_page_o
  );

endmodule
